/* hw/rtl/lc3ie_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lc3ie_pkg: shared types and constants
// Beat payloads, memory port request, instruction opcodes and sequencer states
// for the LC-3 instruction execute block.
// ----------------------------------------------------------------------------
package lc3ie_pkg;

	// request kinds
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_EXEC  = 1'b1;

	// configuration register index (bit 2 of the byte address)
	localparam logic CFG_START_PC = 1'b0;

	localparam logic [15:0] START_PC_RST = 16'h3000;

	// condition codes, one-hot
	localparam logic [2:0] CC_POS  = 3'b001;
	localparam logic [2:0] CC_ZERO = 3'b010;
	localparam logic [2:0] CC_NEG  = 3'b100;

	localparam logic [2:0] LINK_REG = 3'd7;

	typedef enum logic [3:0] {
		OP_BR   = 4'h0,
		OP_ADD  = 4'h1,
		OP_LD   = 4'h2,
		OP_ST   = 4'h3,
		OP_JSR  = 4'h4,
		OP_AND  = 4'h5,
		OP_LDR  = 4'h6,
		OP_STR  = 4'h7,
		OP_RTI  = 4'h8,
		OP_NOT  = 4'h9,
		OP_LDI  = 4'hA,
		OP_STI  = 4'hB,
		OP_JMP  = 4'hC,
		OP_RES  = 4'hD,
		OP_LEA  = 4'hE,
		OP_TRAP = 4'hF
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_EXEC,
		ST_INDIR,
		ST_LOADW,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic        req_type;
		logic [15:0] mem_addr;
		logic [15:0] mem_data;
	} req_t;

	typedef struct packed {
		logic [15:0] pc_after;
		logic [2:0]  cond_code;
		logic [15:0] fetched_instr;
		logic        reg_written;
		logic [2:0]  reg_index;
		logic [15:0] reg_value;
		logic        store_valid;
		logic [15:0] store_addr;
		logic [15:0] store_data;
		logic        unimplemented;
	} rsp_t;

	// one access of the word memory port
	typedef struct packed {
		logic        we;
		logic [15:0] addr;
		logic [15:0] wdata;
	} mem_req_t;

endpackage

/* hw/rtl/lc3_instruction_execute.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lc3_instruction_execute: LC-3 core with private word memory
// Runs one LC-3 instruction per execute beat, or loads one memory word per
// write beat, and reports PC, flags, register write and store per beat.
// ----------------------------------------------------------------------------
// A request beat either writes one word into the block's memory or executes
// the instruction at PC. Every request beat yields exactly one response beat.
// All program state (memory, R0..R7, PC, condition code) lives inside the
// block; the memory has one synchronous port, so every fetch, data read and
// store takes a cycle of that port, and the sequencer serializes them.
// Steps per request after accept: a write goes from idle to finish; an
// execute goes idle (fetch), decode, exec, finish, with loadw added for LD
// and LDR, indir for STI, and indir then loadw for LDI. A new request is
// taken once the sequencer is back to idle, even while the previous response
// still sits in the output register; a stalled response holds the sequencer
// in its last step. Writing start_pc over the APB port also reloads PC; the
// user is to write configuration only while idle; the block does not check.
// ----------------------------------------------------------------------------
module lc3_instruction_execute #(
	parameter int MEM_WORDS = 65536
) (
	input  logic              clk,
	input  logic              arst_n,
	// request channel
	input  logic              req_valid,
	output logic              req_stall,
	input  lc3ie_pkg::req_t   req,
	// response channel
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output lc3ie_pkg::rsp_t   rsp,
	// configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	// flags from a value written to a register
	function automatic logic [2:0] flags_of(input logic [15:0] v);
		logic [2:0] f;
		if (v == 16'h0000) begin
			f = lc3ie_pkg::CC_ZERO;
		end else if (v[15]) begin
			f = lc3ie_pkg::CC_NEG;
		end else begin
			f = lc3ie_pkg::CC_POS;
		end
		return f;
	endfunction

	// sequencer and architectural state
	lc3ie_pkg::state_t state_q, state_d;
	logic [15:0]       pc_q;
	logic [15:0]       start_pc_q;
	logic [2:0]        cc_q;

	// register file: eight words, a valid bit each so that reset reads as zero
	logic [15:0]       rf_mem [8];
	logic [7:0]        rf_vld_q;
	logic [15:0]       rf_a_q;   // base / first source
	logic [15:0]       rf_b_q;   // second source or store data
	logic [2:0]        rf_ra;
	logic [2:0]        rf_rb;
	logic              rf_we;
	logic [2:0]        rf_wa;
	logic [15:0]       rf_wd;
	logic              cc_we;

	// word memory port
	lc3ie_pkg::mem_req_t mem_req;
	logic [15:0]         mem_rdata;

	// per-beat result being built
	logic [15:0]       ir_q;
	logic              rw_q;
	logic [2:0]        ridx_q;
	logic [15:0]       rval_q;
	logic              st_q;
	logic [15:0]       saddr_q;
	logic [15:0]       sdata_q;
	logic              unimpl_q;

	// output register
	logic              rsp_valid_q;
	lc3ie_pkg::rsp_t   rsp_q;
	logic              rsp_load;

	logic              req_accept;
	logic              cfg_wr;

	// decoded fields of the instruction in flight
	lc3ie_pkg::op_t    op;
	logic [15:0]       off9;
	logic [15:0]       off6;
	logic [15:0]       off11;
	logic [15:0]       imm5;
	logic [15:0]       pc_off9;
	logic [15:0]       base_off6;
	logic [15:0]       src2;
	logic              br_taken;
	logic              pc_load;
	logic [15:0]       pc_target;
	logic              exec_rw;
	logic [15:0]       exec_val;
	logic              exec_unimpl;
	logic              fetch_store;

	lc3ie_mem #(
		.MEM_WORDS (MEM_WORDS)
	) u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	// apb: single register, zero wait states
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == lc3ie_pkg::CFG_START_PC);
	assign prdata = (paddr[2] == lc3ie_pkg::CFG_START_PC) ? {16'h0000, start_pc_q} : 32'h0;

	assign req_accept = req_valid && !req_stall;

	// instruction fields, valid from the exec step on
	assign op        = lc3ie_pkg::op_t'(ir_q[15:12]);
	assign off9      = {{7{ir_q[8]}}, ir_q[8:0]};
	assign off6      = {{10{ir_q[5]}}, ir_q[5:0]};
	assign off11     = {{5{ir_q[10]}}, ir_q[10:0]};
	assign imm5      = {{11{ir_q[4]}}, ir_q[4:0]};
	assign pc_off9   = pc_q + off9;
	assign base_off6 = rf_a_q + off6;
	assign src2      = ir_q[5] ? imm5 : rf_b_q;
	assign br_taken  = |(ir_q[11:9] & cc_q);

	// the stored fetch selects which register the second read port needs
	assign fetch_store = (mem_rdata[15:12] == lc3ie_pkg::OP_ST) ||
		(mem_rdata[15:12] == lc3ie_pkg::OP_STI) ||
		(mem_rdata[15:12] == lc3ie_pkg::OP_STR);

	// execute datapath: register results and control transfers
	always_comb begin
		exec_rw     = 1'b0;
		exec_val    = pc_off9;
		exec_unimpl = 1'b0;
		pc_load     = 1'b0;
		pc_target   = rf_a_q;
		unique case (op)
			lc3ie_pkg::OP_BR: begin
				pc_load   = br_taken;
				pc_target = pc_off9;
			end
			lc3ie_pkg::OP_ADD: begin
				exec_rw  = 1'b1;
				exec_val = rf_a_q + src2;
			end
			lc3ie_pkg::OP_AND: begin
				exec_rw  = 1'b1;
				exec_val = rf_a_q & src2;
			end
			lc3ie_pkg::OP_NOT: begin
				exec_rw  = 1'b1;
				exec_val = ~rf_a_q;
			end
			lc3ie_pkg::OP_LEA: begin
				exec_rw  = 1'b1;
				exec_val = pc_off9;
			end
			lc3ie_pkg::OP_JMP: begin
				pc_load   = 1'b1;
				pc_target = rf_a_q;
			end
			lc3ie_pkg::OP_JSR: begin
				// link value is the incremented pc; base was read before the write
				exec_rw   = 1'b1;
				exec_val  = pc_q;
				pc_load   = 1'b1;
				pc_target = ir_q[11] ? (pc_q + off11) : rf_a_q;
			end
			lc3ie_pkg::OP_LD, lc3ie_pkg::OP_LDI, lc3ie_pkg::OP_LDR,
			lc3ie_pkg::OP_ST, lc3ie_pkg::OP_STI, lc3ie_pkg::OP_STR: begin
				// handled through the memory port
			end
			default: begin
				// rti, trap and the reserved opcode
				exec_unimpl = 1'b1;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lc3ie_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_d = (req.req_type == lc3ie_pkg::REQ_EXEC) ?
						lc3ie_pkg::ST_DECODE : lc3ie_pkg::ST_FINISH;
				end
			end
			lc3ie_pkg::ST_DECODE: begin
				state_d = lc3ie_pkg::ST_EXEC;
			end
			lc3ie_pkg::ST_EXEC: begin
				if (op == lc3ie_pkg::OP_LD || op == lc3ie_pkg::OP_LDR) begin
					state_d = lc3ie_pkg::ST_LOADW;
				end else if (op == lc3ie_pkg::OP_LDI || op == lc3ie_pkg::OP_STI) begin
					state_d = lc3ie_pkg::ST_INDIR;
				end else begin
					state_d = lc3ie_pkg::ST_FINISH;
				end
			end
			lc3ie_pkg::ST_INDIR: begin
				state_d = (op == lc3ie_pkg::OP_LDI) ?
					lc3ie_pkg::ST_LOADW : lc3ie_pkg::ST_FINISH;
			end
			lc3ie_pkg::ST_LOADW: begin
				state_d = lc3ie_pkg::ST_FINISH;
			end
			lc3ie_pkg::ST_FINISH: begin
				if (rsp_load) begin
					state_d = lc3ie_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lc3ie_pkg::ST_IDLE;
			end
		endcase
	end

	// sequencer outputs: memory port, register file port, handshakes
	always_comb begin
		req_stall     = (state_q != lc3ie_pkg::ST_IDLE);
		rsp_load      = (state_q == lc3ie_pkg::ST_FINISH) && (!rsp_valid_q || !rsp_stall);
		mem_req.we    = 1'b0;
		mem_req.addr  = pc_q;
		mem_req.wdata = rf_b_q;
		rf_ra         = mem_rdata[8:6];
		rf_rb         = fetch_store ? mem_rdata[11:9] : mem_rdata[2:0];
		rf_we         = 1'b0;
		rf_wa         = ir_q[11:9];
		rf_wd         = exec_val;
		cc_we         = 1'b0;
		case (state_q)
			lc3ie_pkg::ST_IDLE: begin
				// write beat goes straight to memory; execute beat fetches at pc
				if (req_valid && req.req_type == lc3ie_pkg::REQ_WRITE) begin
					mem_req.we    = 1'b1;
					mem_req.addr  = req.mem_addr;
					mem_req.wdata = req.mem_data;
				end
			end
			lc3ie_pkg::ST_EXEC: begin
				mem_req.addr = (op == lc3ie_pkg::OP_LDR || op == lc3ie_pkg::OP_STR) ?
					base_off6 : pc_off9;
				mem_req.we   = (op == lc3ie_pkg::OP_ST) || (op == lc3ie_pkg::OP_STR);
				rf_we        = exec_rw;
				rf_wa        = (op == lc3ie_pkg::OP_JSR) ? lc3ie_pkg::LINK_REG : ir_q[11:9];
				cc_we        = exec_rw && (op != lc3ie_pkg::OP_JSR);
			end
			lc3ie_pkg::ST_INDIR: begin
				// pointer word just read selects the final address
				mem_req.addr = mem_rdata;
				mem_req.we   = (op == lc3ie_pkg::OP_STI);
			end
			lc3ie_pkg::ST_LOADW: begin
				rf_we = 1'b1;
				rf_wd = mem_rdata;
				cc_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lc3ie_pkg::ST_IDLE;
			start_pc_q  <= lc3ie_pkg::START_PC_RST;
			pc_q        <= lc3ie_pkg::START_PC_RST;
			cc_q        <= lc3ie_pkg::CC_ZERO;
			rf_vld_q    <= 8'h00;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				start_pc_q <= pwdata[15:0];
				pc_q       <= pwdata[15:0];
			end else if (state_q == lc3ie_pkg::ST_DECODE) begin
				pc_q <= pc_q + 16'd1;
			end else if (state_q == lc3ie_pkg::ST_EXEC && pc_load) begin
				pc_q <= pc_target;
			end
			if (cc_we) begin
				cc_q <= flags_of(rf_wd);
			end
			if (rf_we) begin
				rf_vld_q[rf_wa] <= 1'b1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// register file storage and registered read ports
	always_ff @(posedge clk) begin
		if (rf_we) begin
			rf_mem[rf_wa] <= rf_wd;
		end
		if (state_q == lc3ie_pkg::ST_DECODE) begin
			rf_a_q <= rf_vld_q[rf_ra] ? rf_mem[rf_ra] : 16'h0000;
			rf_b_q <= rf_vld_q[rf_rb] ? rf_mem[rf_rb] : 16'h0000;
		end
	end

	// result of the beat in flight, then the output register
	always_ff @(posedge clk) begin
		if (req_accept) begin
			ir_q     <= 16'h0000;
			rw_q     <= 1'b0;
			ridx_q   <= 3'd0;
			rval_q   <= 16'h0000;
			st_q     <= 1'b0;
			saddr_q  <= 16'h0000;
			sdata_q  <= 16'h0000;
			unimpl_q <= 1'b0;
		end else begin
			if (state_q == lc3ie_pkg::ST_DECODE) begin
				ir_q <= mem_rdata;
			end
			if (rf_we) begin
				rw_q   <= 1'b1;
				ridx_q <= rf_wa;
				rval_q <= rf_wd;
			end
			if (mem_req.we) begin
				st_q    <= 1'b1;
				saddr_q <= mem_req.addr;
				sdata_q <= mem_req.wdata;
			end
			if (state_q == lc3ie_pkg::ST_EXEC && exec_unimpl) begin
				unimpl_q <= 1'b1;
			end
		end
		if (rsp_load) begin
			rsp_q.pc_after      <= pc_q;
			rsp_q.cond_code     <= cc_q;
			rsp_q.fetched_instr <= ir_q;
			rsp_q.reg_written   <= rw_q;
			rsp_q.reg_index     <= ridx_q;
			rsp_q.reg_value     <= rval_q;
			rsp_q.store_valid   <= st_q;
			rsp_q.store_addr    <= saddr_q;
			rsp_q.store_data    <= sdata_q;
			rsp_q.unimplemented <= unimpl_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* hw/rtl/lc3ie_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lc3ie_mem: word memory
// Single-port synchronous memory, one access per cycle, registered read data.
// Addresses at or above the depth drop writes and read back as zero.
// ----------------------------------------------------------------------------
module lc3ie_mem #(
	parameter int MEM_WORDS = 65536
) (
	input  logic                 clk,
	input  lc3ie_pkg::mem_req_t  req,
	output logic [15:0]          rdata
);

	localparam int AW = $clog2(MEM_WORDS);

	logic [15:0]   words [MEM_WORDS];
	logic [AW-1:0] idx;
	logic          in_range;
	logic [15:0]   rd_q;
	logic          oor_q;

	assign idx      = req.addr[AW-1:0];
	assign in_range = {16'b0, req.addr} < 32'(MEM_WORDS);

	always_ff @(posedge clk) begin
		if (req.we && in_range) begin
			words[idx] <= req.wdata;
		end
		rd_q  <= words[idx];
		oor_q <= !in_range;
	end

	assign rdata = oor_q ? 16'h0000 : rd_q;

endmodule

/* hw/rtl/lc3ie_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lc3ie_chk: port checker
// Watches the response channel of the execute block and flags results that
// no legal instruction can produce.
// ----------------------------------------------------------------------------
module lc3ie_chk (
	input logic            clk,
	input logic            arst_n,
	input logic            rsp_valid,
	input logic            rsp_stall,
	input lc3ie_pkg::rsp_t rsp
);

	// a stalled response beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// condition code is always one-hot
	a_cc_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $onehot(rsp.cond_code))
		else $error("condition code not one-hot");

	// no register write means empty register fields
	a_rw_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.reg_written |-> rsp.reg_index == 3'd0 && rsp.reg_value == 16'h0)
		else $error("register fields set without a write");

	// a store never writes a register and is never a no-op
	a_st_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.store_valid |-> !rsp.reg_written && !rsp.unimplemented)
		else $error("store combined with register write or no-op");

	// a write beat reports nothing but pc and flags
	a_wr_beat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.fetched_instr == 16'h0 |-> !rsp.reg_written && !rsp.store_valid)
		else $error("write beat reported a side effect");

endmodule

bind lc3_instruction_execute lc3ie_chk u_lc3ie_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
